[src/pwmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_pkg
// Shared types and constants of the register-mapped PWM controller.
// ----------------------------------------------------------------------------
package pwmc_pkg;

  // Operation codes on the request channel
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Register map
  localparam logic [7:0] MODE_ADDR       = 8'h00;
  localparam logic [7:0] CHAN_BASE       = 8'h06;
  localparam logic [7:0] PRESCALE_ADDR   = 8'hFE;
  localparam int         SLEEP_BIT       = 4;
  localparam int         RESTART_BIT     = 7;
  localparam logic [7:0] MODE_STORE_MASK = 8'h7F;
  localparam logic [7:0] PRESCALE_RESET  = 8'd30;

  // Widths of the fixed result and command slot fields
  localparam int PWM_BITS  = 16;
  localparam int SLOT_BITS = 5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WR_MODE,
    CMD_WR_PRESCALE,
    CMD_WR_CHAN,
    CMD_RD_MODE,
    CMD_RD_PRESCALE,
    CMD_RD_CHAN,
    CMD_TICK
  } cmd_e;

  typedef struct packed {
    cmd_e                 kind;
    logic [SLOT_BITS-1:0] slot;
    logic                 sub;
    logic [7:0]           data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[src/pwmc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_if
// Request and response channels of the PWM controller (valid/ready).
// ----------------------------------------------------------------------------
interface pwmc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] reg_address;
  logic [7:0] write_data;

  modport source (output valid, output operation, output reg_address,
                  output write_data, input ready);
  modport sink   (input valid, input operation, input reg_address,
                  input write_data, output ready);
endinterface

interface pwmc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [15:0] pwm_outputs;

  modport source (output valid, output read_data, output pwm_outputs, input ready);
  modport sink   (input valid, input read_data, input pwm_outputs, output ready);
endinterface

[src/pwmc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_front
// Accept requests and decode them into register commands.
// ----------------------------------------------------------------------------
module pwmc_front #(
  parameter int CHANNELS = 16
) (
  pwmc_req_if.sink              req_i,
  input  pwmc_pkg::queue_stat_t stat_i,
  output logic                  push_o,
  output pwmc_pkg::cmd_t        cmd_o
);
  import pwmc_pkg::*;

  localparam logic [8:0] CHAN_LIMIT = 9'(4 * CHANNELS);

  logic [7:0] rel;
  logic       in_chan;

  assign req_i.ready = !stat_i.full;
  assign push_o      = req_i.valid && !stat_i.full;

  always_comb begin
    rel     = req_i.reg_address - CHAN_BASE;
    in_chan = (req_i.reg_address >= CHAN_BASE) && ({1'b0, rel} < CHAN_LIMIT);

    cmd_o.slot = {rel[5:2], rel[1]};
    cmd_o.sub  = rel[0];
    cmd_o.data = req_i.write_data;
    cmd_o.kind = CMD_NOP;

    unique case (req_i.operation)
      OP_WRITE: begin
        if (req_i.reg_address == MODE_ADDR) begin
          cmd_o.kind = CMD_WR_MODE;
        end else if (req_i.reg_address == PRESCALE_ADDR) begin
          cmd_o.kind = CMD_WR_PRESCALE;
        end else if (in_chan) begin
          cmd_o.kind = CMD_WR_CHAN;
        end
      end
      OP_READ: begin
        if (req_i.reg_address == MODE_ADDR) begin
          cmd_o.kind = CMD_RD_MODE;
        end else if (req_i.reg_address == PRESCALE_ADDR) begin
          cmd_o.kind = CMD_RD_PRESCALE;
        end else if (in_chan) begin
          cmd_o.kind = CMD_RD_CHAN;
        end
      end
      OP_TICK: cmd_o.kind = CMD_TICK;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

[src/pwmc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_queue
// Short command FIFO between the decode front and the execute back.
// ----------------------------------------------------------------------------
module pwmc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pwmc_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output pwmc_pkg::cmd_t        head_o,
  output pwmc_pkg::queue_stat_t stat_o
);
  import pwmc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign head_o       = slots_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold stored commands; write the incoming one at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");
`endif

endmodule

[src/pwmc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_back
// Execute register commands and ticks, compare channels, register results.
// ----------------------------------------------------------------------------
module pwmc_back #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pwmc_pkg::cmd_t        head_i,
  input  pwmc_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  pwmc_rsp_if.source            rsp_o
);
  import pwmc_pkg::*;

  localparam int ENTRIES = 2 * CHANNELS;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [7:0] HIGH_MASK = 8'((1 << (COUNT_BITS - 8)) - 1);

  logic [COUNT_BITS-1:0] counts_q [ENTRIES];
  logic [7:0]            mode_q, mode_d;
  logic [7:0]            prescale_q, prescale_d;
  logic [7:0]            div_q, div_d;
  logic [COUNT_BITS-1:0] period_q, period_d;

  logic                  rsp_valid_q;
  logic [7:0]            rsp_rd_q, rsp_rd_d;
  logic [PWM_BITS-1:0]   rsp_pwm_q, rsp_pwm_d;

  logic [SLOT_W-1:0]     idx;
  logic [15:0]           cur16;
  logic [COUNT_BITS-1:0] wval;
  logic                  wr_chan;
  logic                  asleep;

  assign pop_o  = !stat_i.empty && (!rsp_valid_q || rsp_o.ready);
  assign idx    = head_i.slot[SLOT_W-1:0];
  assign cur16  = 16'(counts_q[idx]);
  assign asleep = mode_q[SLEEP_BIT];
  assign wval   = head_i.sub ? COUNT_BITS'({head_i.data & HIGH_MASK, cur16[7:0]})
                             : COUNT_BITS'({cur16[15:8], head_i.data});

  always_comb begin
    mode_d     = mode_q;
    prescale_d = prescale_q;
    div_d      = div_q;
    period_d   = period_q;
    rsp_rd_d   = '0;
    wr_chan    = 1'b0;
    if (pop_o) begin
      unique case (head_i.kind)
        CMD_WR_MODE: begin
          if (head_i.data[RESTART_BIT]) begin
            div_d    = '0;
            period_d = '0;
          end
          mode_d = head_i.data & MODE_STORE_MASK;
        end
        CMD_WR_PRESCALE: begin
          if (asleep) begin
            prescale_d = head_i.data;
          end
        end
        CMD_WR_CHAN:     wr_chan  = 1'b1;
        CMD_RD_MODE:     rsp_rd_d = mode_q;
        CMD_RD_PRESCALE: rsp_rd_d = prescale_q;
        CMD_RD_CHAN:     rsp_rd_d = head_i.sub ? cur16[15:8] : cur16[7:0];
        CMD_TICK: begin
          if (!asleep) begin
            if (div_q >= prescale_q) begin
              div_d    = '0;
              period_d = period_q + 1'b1;
            end else begin
              div_d = div_q + 1'b1;
            end
          end
        end
        CMD_NOP: ;
      endcase
    end
  end

  // Compare every channel against the updated period, with this command's write
  always_comb begin
    logic [COUNT_BITS-1:0] on_v;
    logic [COUNT_BITS-1:0] off_v;
    rsp_pwm_d = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      on_v  = (wr_chan && idx == SLOT_W'(2 * n))     ? wval : counts_q[2 * n];
      off_v = (wr_chan && idx == SLOT_W'(2 * n + 1)) ? wval : counts_q[2 * n + 1];
      rsp_pwm_d[n] = (period_d >= on_v) && (period_d < off_v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      prescale_q  <= PRESCALE_RESET;
      div_q       <= '0;
      period_q    <= '0;
      rsp_valid_q <= 1'b0;
      for (int e = 0; e < ENTRIES; e++) begin
        counts_q[e] <= '0;
      end
    end else begin
      mode_q     <= mode_d;
      prescale_q <= prescale_d;
      div_q      <= div_d;
      period_q   <= period_d;
      if (wr_chan) begin
        counts_q[idx] <= wval;
      end
      if (pop_o) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Load the result slot on every executed command
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_rd_q  <= rsp_rd_d;
      rsp_pwm_q <= rsp_pwm_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_rd_q;
  assign rsp_o.pwm_outputs = rsp_pwm_q;

`ifndef ASSERT_OFF
  a_period_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(period_q))
    else $error("period counter moved without a command");
  a_prescale_awake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !asleep |=> $stable(prescale_q))
    else $error("prescale changed while awake");
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !(head_i.kind == CMD_RD_MODE || head_i.kind == CMD_RD_PRESCALE ||
               head_i.kind == CMD_RD_CHAN) |=> rsp_rd_q == '0)
    else $error("read data on a non-read command");
  a_unused_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (32'(rsp_pwm_q) >> CHANNELS) == '0)
    else $error("output bit set above channel count");
`endif

endmodule

[src/pwm_controller_registers_top.sv]
`timescale 1ns / 1ps
// A request is queued; the back end pops it and registers its response.
// Throughput: one request per cycle, sustained; the back end executes one command
//   per cycle whenever the response register is free or being drained.
// A stalled response holds; the two-entry command queue takes two more requests.
// Reset (rst_ni, async, active low): mode 0, prescale 30, all channel counts 0,
//   divider and period 0, queue and response slot empty. No clearing pass.
// ----------------------------------------------------------------------------
// pwm_controller_registers_top
// Register-mapped multi-channel PWM controller with byte register access.
// ----------------------------------------------------------------------------
module pwm_controller_registers_top #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pwmc_req_if.sink   req_i,
  pwmc_rsp_if.source rsp_o
);
  import pwmc_pkg::*;

  // Front to queue
  logic        push;
  cmd_t        cmd;
  // Queue to back
  logic        pop;
  cmd_t        head;
  queue_stat_t stat;

  // Decode: classify each transfer into a command (mode, prescale, channel
  // byte, tick, or no-op for unmapped addresses and the unused operation).
  pwmc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .req_i  (req_i),
    .stat_i (stat),
    .push_o (push),
    .cmd_o  (cmd)
  );

  // Buffer decoded commands so decode and execute stall independently.
  pwmc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (stat)
  );

  // Execute: own the register file, the prescale divider and the period
  // counter; every command produces one response carrying read data and the
  // channel levels after the update.
  pwmc_back #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

endmodule
